/* hw/rtl/text_console_cursor_engine_unit_macros.svh */
// Assertion macros for the text console cursor engine checker.
`ifndef TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH
`define TEXT_CONSOLE_CURSOR_ENGINE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define TCCE_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TCCE_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/tcce_pkg.sv */
// Shared constants and controller/datapath interface types for the text console.
package tcce_pkg;

    localparam int CON_COLS = 80;
    localparam int CON_ROWS = 25;
    localparam int IDX_W    = 11;
    localparam int BYTE_W   = 8;

    localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [BYTE_W-1:0] CH_RETURN  = 8'd13;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'd32;
    localparam logic [BYTE_W-1:0] ATTR_RESET = 8'd7;

    typedef struct packed {
        logic clear_en;
        logic put_en;
        logic read_en;
        logic read_done;
        logic scroll_rd;
        logic scroll_done;
    } cmd_t;

    typedef struct packed {
        logic scroll_need;
        logic sweep_last;
        logic pend_full;
    } status_t;

endpackage

/* hw/rtl/text_console_cursor_engine_unit.sv */
// Top level of the text console cursor engine.
//
//  channel | handshake             | payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid / in_ready   | func, char_code, cell_index
//  out     | out_valid / out_ready | cursor_index, scrolled, read_char, read_attr
//  cfg     | cfg_valid / cfg_ready | cfg_data (text attribute)
//
//  A put that does not scroll is handled in IDLE; a read goes through READ (registered memory read).
//  A put that scrolls sweeps through the SCROLL and SCEND states: one cell copy per cycle through the
//  single read and single write port of the cell memory.
//  After reset a clearing pass writes ROWS*COLS cells, one a cycle, with in_ready low.
//  One result is buffered behind the output register, so an item is taken while a
//  result waits; in_ready drops once both are full.
module text_console_cursor_engine_unit
    import tcce_pkg::*;
#(
    parameter int COLS = CON_COLS,
    parameter int ROWS = CON_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              func,
    input  logic [BYTE_W-1:0] char_code,
    input  logic [IDX_W-1:0]  cell_index,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [IDX_W-1:0]  cursor_index,
    output logic              scrolled,
    output logic [BYTE_W-1:0] read_char,
    output logic [BYTE_W-1:0] read_attr,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [BYTE_W-1:0] cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tcce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .func     (func),
        .status   (status),
        .cmd      (cmd)
    );

    tcce_dp #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_data     (cfg_data),
        .char_code    (char_code),
        .cell_index   (cell_index),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .cursor_index (cursor_index),
        .scrolled     (scrolled),
        .read_char    (read_char),
        .read_attr    (read_attr)
    );

endmodule

/* hw/rtl/tcce_ctrl.sv */
// Sequencer for reset clearing, put, read and scroll sweeps.
module tcce_ctrl
    import tcce_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  logic    func,
    input  status_t status,
    output cmd_t    cmd
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_READ   = 5'b00100,
        S_SCROLL = 5'b01000,
        S_SCEND  = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_fire;

    assign in_ready = (state_reg == S_IDLE) && !status.pend_full;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (func)
                    begin
                        cmd.read_en = 1'b1;
                        state_next  = S_READ;
                    end
                    else
                    begin
                        cmd.put_en = 1'b1;
                        if (status.scroll_need)
                        begin
                            state_next = S_SCROLL;
                        end
                    end
                end
            end
            S_READ:
            begin
                cmd.read_done = 1'b1;
                state_next    = S_IDLE;
            end
            S_SCROLL:
            begin
                cmd.scroll_rd = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_SCEND;
                end
            end
            S_SCEND:
            begin
                cmd.scroll_done = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

/* hw/rtl/tcce_dp.sv */
// Cell memory, cursor registers, sweep counter and result buffering.
module tcce_dp
    import tcce_pkg::*;
#(
    parameter int COLS = CON_COLS,
    parameter int ROWS = CON_ROWS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  cmd_t              cmd,
    output status_t           status,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_data,
    input  logic [BYTE_W-1:0] char_code,
    input  logic [IDX_W-1:0]  cell_index,
    input  logic              out_ready,
    output logic              out_valid,
    output logic [IDX_W-1:0]  cursor_index,
    output logic              scrolled,
    output logic [BYTE_W-1:0] read_char,
    output logic [BYTE_W-1:0] read_attr
);

    localparam int CELLS = COLS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(COLS);
    localparam int RW    = $clog2(ROWS);
    localparam int XW    = (AW > IDX_W) ? AW : IDX_W;
    localparam logic [AW-1:0] LAST_A = AW'(CELLS - 1);
    localparam logic [AW-1:0] BOT_A  = AW'((ROWS - 1) * COLS);
    localparam logic [AW-1:0] COLS_A = AW'(COLS);
    localparam logic [CW-1:0] LAST_C = CW'(COLS - 1);
    localparam logic [RW-1:0] LAST_R = RW'(ROWS - 1);

    typedef struct packed {
        logic [IDX_W-1:0]  cursor;
        logic              scr;
        logic [BYTE_W-1:0] rchar;
        logic [BYTE_W-1:0] rattr;
    } res_t;

    logic [2*BYTE_W-1:0] mem [CELLS];

    logic [BYTE_W-1:0]   attr_reg;
    logic [RW-1:0]       row_reg, row_next;
    logic [CW-1:0]       col_reg, col_next;
    logic [AW-1:0]       pos_reg, pos_next;
    logic [AW-1:0]       sweep_reg;
    logic [AW-1:0]       wr_addr_reg;
    logic                wr_bot_reg;
    logic                wr_pend_reg;
    logic [2*BYTE_W-1:0] rdata_reg;
    logic                rd_ok_reg;
    logic                out_valid_reg, out_valid_next;
    logic                pend_valid_reg, pend_valid_next;
    res_t                out_reg;
    res_t                pend_reg;

    logic                is_nl, is_cr, at_last_col, at_bot;
    logic [XW-1:0]       rd_idx_x;
    logic                rd_ok;
    logic                rd_en;
    logic [AW-1:0]       rd_addr;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [2*BYTE_W-1:0] wr_data;
    logic                finish;
    logic                out_free;
    logic                load_out_res, load_pend, load_out_pend;
    logic [XW-1:0]       pos_x;
    res_t                res;

    assign is_nl       = (char_code == CH_NEWLINE);
    assign is_cr       = (char_code == CH_RETURN);
    assign at_last_col = (col_reg == LAST_C);
    assign at_bot      = (row_reg == LAST_R);

    assign status.scroll_need = at_bot && (is_nl || (!is_cr && at_last_col));
    assign status.sweep_last  = (sweep_reg == LAST_A);
    assign status.pend_full   = pend_valid_reg;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        pos_next = pos_reg;
        if (cmd.put_en)
        begin
            priority if (is_nl)
            begin
                col_next = '0;
                if (at_bot)
                begin
                    pos_next = BOT_A;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    pos_next = pos_reg - AW'(col_reg) + COLS_A;
                end
            end
            else if (is_cr)
            begin
                col_next = '0;
                pos_next = pos_reg - AW'(col_reg);
            end
            else if (at_last_col)
            begin
                col_next = '0;
                if (at_bot)
                begin
                    pos_next = BOT_A;
                end
                else
                begin
                    row_next = row_reg + 1'b1;
                    pos_next = pos_reg + 1'b1;
                end
            end
            else
            begin
                col_next = col_reg + 1'b1;
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    assign rd_idx_x = XW'(cell_index);
    assign rd_ok    = (rd_idx_x < XW'(CELLS));
    assign rd_en    = cmd.scroll_rd || (cmd.read_en && rd_ok);

    always_comb
    begin
        if (cmd.scroll_rd)
        begin
            rd_addr = (sweep_reg < BOT_A) ? (sweep_reg + COLS_A) : sweep_reg;
        end
        else
        begin
            rd_addr = rd_idx_x[AW-1:0];
        end
    end

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sweep_reg;
        wr_data = {ATTR_RESET, CH_SPACE};
        priority if (cmd.clear_en)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.put_en && !is_nl && !is_cr)
        begin
            wr_en   = 1'b1;
            wr_addr = pos_reg;
            wr_data = {attr_reg, char_code};
        end
        else if (wr_pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = wr_addr_reg;
            wr_data = wr_bot_reg ? {rdata_reg[2*BYTE_W-1:BYTE_W], CH_SPACE} : rdata_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        wr_addr_reg <= sweep_reg;
        wr_bot_reg  <= (sweep_reg >= BOT_A);
        if (cmd.read_en)
        begin
            rd_ok_reg <= rd_ok;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg    <= ATTR_RESET;
            row_reg     <= '0;
            col_reg     <= '0;
            pos_reg     <= '0;
            sweep_reg   <= '0;
            wr_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                attr_reg <= cfg_data;
            end
            row_reg     <= row_next;
            col_reg     <= col_next;
            pos_reg     <= pos_next;
            wr_pend_reg <= cmd.scroll_rd;
            if (cmd.clear_en || cmd.scroll_rd)
            begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + 1'b1;
            end
        end
    end

    assign finish = (cmd.put_en && !status.scroll_need) || cmd.read_done || cmd.scroll_done;
    assign pos_x  = XW'(cmd.put_en ? pos_next : pos_reg);

    always_comb
    begin
        res.cursor = pos_x[IDX_W-1:0];
        res.scr    = cmd.scroll_done;
        res.rchar  = '0;
        res.rattr  = '0;
        if (cmd.read_done && rd_ok_reg)
        begin
            res.rchar = rdata_reg[BYTE_W-1:0];
            res.rattr = rdata_reg[2*BYTE_W-1:BYTE_W];
        end
    end

    assign out_free      = !out_valid_reg || out_ready;
    assign load_out_res  = finish && out_free;
    assign load_pend     = finish && !out_free;
    assign load_out_pend = !finish && pend_valid_reg && out_free;

    assign out_valid_next  = load_out_res || load_out_pend || (out_valid_reg && !out_ready);
    assign pend_valid_next = load_pend || (pend_valid_reg && !load_out_pend);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out_res)
        begin
            out_reg <= res;
        end
        else if (load_out_pend)
        begin
            out_reg <= pend_reg;
        end
        if (load_pend)
        begin
            pend_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign cursor_index = out_reg.cursor;
    assign scrolled     = out_reg.scr;
    assign read_char    = out_reg.rchar;
    assign read_attr    = out_reg.rattr;

endmodule

/* hw/rtl/tcce_checker.sv */
// Port-level checker for the text console cursor engine, bound to the top level.
`include "text_console_cursor_engine_unit_macros.svh"

module tcce_checker
    import tcce_pkg::*;
#(
    parameter int COLS = CON_COLS,
    parameter int ROWS = CON_ROWS
)
(
    input logic              clk,
    input logic              rst_n,
    input logic              out_valid,
    input logic              out_ready,
    input logic [IDX_W-1:0]  cursor_index,
    input logic              scrolled,
    input logic [BYTE_W-1:0] read_char,
    input logic [BYTE_W-1:0] read_attr
);

    localparam logic [IDX_W-1:0] BOT_IDX = IDX_W'((ROWS - 1) * COLS);

    `TCCE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cursor_index) && $stable(scrolled) && $stable(read_char) && $stable(read_attr), "result changed while stalled")

    `TCCE_ASSERT_IMP(a_scroll_cursor, out_valid && scrolled, cursor_index == BOT_IDX, "scroll left cursor off the bottom row start")

    `TCCE_ASSERT_IMP(a_scroll_no_read, out_valid && scrolled, read_char == '0 && read_attr == '0, "scrolling put carries read data")

endmodule

bind text_console_cursor_engine_unit tcce_checker #(
    .COLS (COLS),
    .ROWS (ROWS)
) u_tcce_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cursor_index (cursor_index),
    .scrolled     (scrolled),
    .read_char    (read_char),
    .read_attr    (read_attr)
);
